// File: rtl/core/pidaw_pkg.sv
// Shared types and constants for the PID anti-windup unit.
`timescale 1ns / 1ps
`default_nettype none
package pidaw_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_GAIN_P        = 3'd0;
    localparam logic [2:0] CFG_GAIN_I        = 3'd1;
    localparam logic [2:0] CFG_GAIN_D        = 3'd2;
    localparam logic [2:0] CFG_DRIVE_FLOOR   = 3'd3;
    localparam logic [2:0] CFG_DRIVE_CEILING = 3'd4;
    localparam logic [2:0] CFG_DERIV_ON_MEAS = 3'd5;

    // Divider takes two quotient bits per cycle over a 50-bit dividend
    localparam int DIV_BITS  = 50;
    localparam int DIV_STEPS = DIV_BITS / 2;

    typedef enum logic [4:0] {
        S_IDLE, S_PH, S_PL, S_PT, S_ZERO, S_DINIT, S_DIV, S_DQ,
        S_DH, S_DL, S_DT, S_NH, S_NL, S_NT, S_IH, S_IL, S_IT,
        S_SUM, S_CHK, S_AH, S_AL, S_AT, S_SUM2, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        MS_P, MS_D, MS_N, MS_I, MS_A
    } mul_src_t;

    typedef enum logic [2:0] {
        TK_NONE, TK_P, TK_D, TK_I, TK_TENT
    } take_t;

    typedef struct packed {
        logic     load;
        mul_src_t mul_src;
        logic     mul_hi;
        logic     mul_lo;
        take_t    take;
        logic     div_init;
        logic     div_step;
        logic     deriv_take;
        logic     sum;
        logic     sum_id;
        logic     check;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic clr;
        logic dt_zero;
        logic div_last;
        logic held_now;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/pid_controller_anti_windup_unit.sv
// Top level of the fixed-point PID unit with conditional-integration anti-windup.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid/cfg_ready    cfg_index[2:0], cfg_data[31:0]
//   in        in         in_valid/in_ready      mode, target, sensed, step_time
//   out       out        out_valid/out_ready    drive, raw_sum, integral_held
//
// One request at a time. A run request with nonzero step runs the radix-4 divider
// for the derivative and the shared two-pass 32x24 multiplier, and runs longer when
// the integral is withheld. Zero step and clear skip the divider.
// The result sits in an output register, so a new request is taken while it
// waits. rst_n clears state and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_anti_windup_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [2:0]          cfg_index,
    input  wire  [31:0]         cfg_data,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 mode,
    input  wire  signed [31:0]  target,
    input  wire  signed [31:0]  sensed,
    input  wire  [15:0]         step_time,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  drive,
    output logic signed [39:0]  raw_sum,
    output logic                integral_held
);

    pidaw_pkg::cmd_t  cmd;
    pidaw_pkg::stat_t stat;

    pidaw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pidaw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .target        (target),
        .sensed        (sensed),
        .step_time     (step_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive         (drive),
        .raw_sum       (raw_sum),
        .integral_held (integral_held)
    );

endmodule
`default_nettype wire

// File: rtl/core/pidaw_ctrl.sv
// Sequencer for the PID update: steps the datapath through each term.
`timescale 1ns / 1ps
`default_nettype none
module pidaw_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  pidaw_pkg::stat_t    stat,
    output pidaw_pkg::cmd_t     cmd
);

    pidaw_pkg::state_t state_reg;
    pidaw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidaw_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidaw_pkg::S_IDLE:  if (in_valid) state_next = pidaw_pkg::S_PH;
            pidaw_pkg::S_PH:    state_next = pidaw_pkg::S_PL;
            pidaw_pkg::S_PL:    state_next = pidaw_pkg::S_PT;
            pidaw_pkg::S_PT:
            begin
                if (stat.clr)
                    state_next = pidaw_pkg::S_FIN;
                else if (stat.dt_zero)
                    state_next = pidaw_pkg::S_ZERO;
                else
                    state_next = pidaw_pkg::S_DINIT;
            end
            pidaw_pkg::S_ZERO:  state_next = pidaw_pkg::S_FIN;
            pidaw_pkg::S_DINIT: state_next = pidaw_pkg::S_DIV;
            pidaw_pkg::S_DIV:   if (stat.div_last) state_next = pidaw_pkg::S_DQ;
            pidaw_pkg::S_DQ:    state_next = pidaw_pkg::S_DH;
            pidaw_pkg::S_DH:    state_next = pidaw_pkg::S_DL;
            pidaw_pkg::S_DL:    state_next = pidaw_pkg::S_DT;
            pidaw_pkg::S_DT:    state_next = pidaw_pkg::S_NH;
            pidaw_pkg::S_NH:    state_next = pidaw_pkg::S_NL;
            pidaw_pkg::S_NL:    state_next = pidaw_pkg::S_NT;
            pidaw_pkg::S_NT:    state_next = pidaw_pkg::S_IH;
            pidaw_pkg::S_IH:    state_next = pidaw_pkg::S_IL;
            pidaw_pkg::S_IL:    state_next = pidaw_pkg::S_IT;
            pidaw_pkg::S_IT:    state_next = pidaw_pkg::S_SUM;
            pidaw_pkg::S_SUM:   state_next = pidaw_pkg::S_CHK;
            pidaw_pkg::S_CHK:
            begin
                if (stat.held_now)
                    state_next = pidaw_pkg::S_AH;
                else
                    state_next = pidaw_pkg::S_FIN;
            end
            pidaw_pkg::S_AH:    state_next = pidaw_pkg::S_AL;
            pidaw_pkg::S_AL:    state_next = pidaw_pkg::S_AT;
            pidaw_pkg::S_AT:    state_next = pidaw_pkg::S_SUM2;
            pidaw_pkg::S_SUM2:  state_next = pidaw_pkg::S_FIN;
            pidaw_pkg::S_FIN:   if (stat.out_free) state_next = pidaw_pkg::S_IDLE;
            default:            state_next = pidaw_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            pidaw_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pidaw_pkg::S_PH:
            begin
                cmd.mul_src = pidaw_pkg::MS_P;
                cmd.mul_hi  = 1'b1;
            end
            pidaw_pkg::S_PL:
            begin
                cmd.mul_src = pidaw_pkg::MS_P;
                cmd.mul_lo  = 1'b1;
            end
            pidaw_pkg::S_PT:    cmd.take = pidaw_pkg::TK_P;
            pidaw_pkg::S_ZERO:  cmd.sum  = 1'b1;
            pidaw_pkg::S_DINIT: cmd.div_init = 1'b1;
            pidaw_pkg::S_DIV:   cmd.div_step = 1'b1;
            pidaw_pkg::S_DQ:    cmd.deriv_take = 1'b1;
            pidaw_pkg::S_DH:
            begin
                cmd.mul_src = pidaw_pkg::MS_D;
                cmd.mul_hi  = 1'b1;
            end
            pidaw_pkg::S_DL:
            begin
                cmd.mul_src = pidaw_pkg::MS_D;
                cmd.mul_lo  = 1'b1;
            end
            pidaw_pkg::S_DT:    cmd.take = pidaw_pkg::TK_D;
            pidaw_pkg::S_NH:
            begin
                cmd.mul_src = pidaw_pkg::MS_N;
                cmd.mul_hi  = 1'b1;
            end
            pidaw_pkg::S_NL:
            begin
                cmd.mul_src = pidaw_pkg::MS_N;
                cmd.mul_lo  = 1'b1;
            end
            pidaw_pkg::S_NT:    cmd.take = pidaw_pkg::TK_TENT;
            pidaw_pkg::S_IH:
            begin
                cmd.mul_src = pidaw_pkg::MS_I;
                cmd.mul_hi  = 1'b1;
            end
            pidaw_pkg::S_IL:
            begin
                cmd.mul_src = pidaw_pkg::MS_I;
                cmd.mul_lo  = 1'b1;
            end
            pidaw_pkg::S_IT:    cmd.take = pidaw_pkg::TK_I;
            pidaw_pkg::S_SUM:
            begin
                cmd.sum    = 1'b1;
                cmd.sum_id = 1'b1;
            end
            pidaw_pkg::S_CHK:   cmd.check = 1'b1;
            pidaw_pkg::S_AH:
            begin
                cmd.mul_src = pidaw_pkg::MS_A;
                cmd.mul_hi  = 1'b1;
            end
            pidaw_pkg::S_AL:
            begin
                cmd.mul_src = pidaw_pkg::MS_A;
                cmd.mul_lo  = 1'b1;
            end
            pidaw_pkg::S_AT:    cmd.take = pidaw_pkg::TK_I;
            pidaw_pkg::S_SUM2:
            begin
                cmd.sum    = 1'b1;
                cmd.sum_id = 1'b1;
            end
            pidaw_pkg::S_FIN:   cmd.finish = stat.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/pidaw_dp.sv
// Datapath: config registers, shared multiplier, serial divider, sums and state.
`timescale 1ns / 1ps
`default_nettype none
module pidaw_dp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  pidaw_pkg::cmd_t     cmd,
    output pidaw_pkg::stat_t    stat,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [2:0]          cfg_index,
    input  wire  [31:0]         cfg_data,
    input  wire                 mode,
    input  wire  signed [31:0]  target,
    input  wire  signed [31:0]  sensed,
    input  wire  [15:0]         step_time,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  drive,
    output logic signed [39:0]  raw_sum,
    output logic                integral_held
);

    // configuration
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] floor_reg, ceil_reg;
    logic               dom_reg;

    // controller state
    logic signed [47:0] acc_reg;
    logic signed [31:0] last_sensed_reg;
    logic signed [32:0] last_err_reg;
    logic               hist_reg;
    logic signed [39:0] last_raw_reg;

    // request operands and working values
    logic               mode_reg;
    logic signed [31:0] sensed_reg;
    logic [15:0]        dt_reg;
    logic signed [32:0] err_reg;
    logic signed [48:0] p_reg, d_reg, i_reg;
    logic signed [47:0] tent_reg;
    logic signed [31:0] deriv_reg;
    logic signed [39:0] raw_reg;
    logic               held_reg;
    logic [79:0]        prod_reg;
    logic               neg_reg;
    logic [49:0]        quo_reg;
    logic [15:0]        rem_reg;
    logic               dneg_reg;
    logic [4:0]         cnt_reg;
    logic               out_valid_reg;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= 32'sd65536;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            floor_reg  <= 32'sh8000_0000;
            ceil_reg   <= 32'sh7FFF_FFFF;
            dom_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pidaw_pkg::CFG_GAIN_P:        gain_p_reg <= cfg_data;
                pidaw_pkg::CFG_GAIN_I:        gain_i_reg <= cfg_data;
                pidaw_pkg::CFG_GAIN_D:        gain_d_reg <= cfg_data;
                pidaw_pkg::CFG_DRIVE_FLOOR:   floor_reg  <= cfg_data;
                pidaw_pkg::CFG_DRIVE_CEILING: ceil_reg   <= cfg_data;
                pidaw_pkg::CFG_DERIV_ON_MEAS: dom_reg    <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // ---------------- multiplier operands (magnitude and sign)
    logic [31:0] a_mag;
    logic        a_neg;
    logic [47:0] b_mag;
    logic        b_neg;
    logic [32:0] err_mag;
    logic [31:0] deriv_mag;

    assign err_mag   = err_reg[32] ? (~err_reg + 33'd1) : err_reg;
    assign deriv_mag = deriv_reg[31] ? (~deriv_reg + 32'd1) : deriv_reg;

    always_comb
    begin
        a_mag = '0;
        a_neg = 1'b0;
        b_mag = '0;
        b_neg = 1'b0;
        case (cmd.mul_src)
            pidaw_pkg::MS_P:
            begin
                a_mag = gain_p_reg[31] ? (~gain_p_reg + 32'd1) : gain_p_reg;
                a_neg = gain_p_reg[31];
                b_mag = 48'(err_mag);
                b_neg = err_reg[32];
            end
            pidaw_pkg::MS_D:
            begin
                a_mag = gain_d_reg[31] ? (~gain_d_reg + 32'd1) : gain_d_reg;
                a_neg = gain_d_reg[31];
                b_mag = 48'(deriv_mag);
                b_neg = deriv_reg[31];
            end
            pidaw_pkg::MS_N:
            begin
                a_mag = 32'(dt_reg);
                b_mag = 48'(err_mag);
                b_neg = err_reg[32];
            end
            pidaw_pkg::MS_I:
            begin
                a_mag = gain_i_reg[31] ? (~gain_i_reg + 32'd1) : gain_i_reg;
                a_neg = gain_i_reg[31];
                b_mag = tent_reg[47] ? (~tent_reg + 48'd1) : tent_reg;
                b_neg = tent_reg[47];
            end
            pidaw_pkg::MS_A:
            begin
                a_mag = gain_i_reg[31] ? (~gain_i_reg + 32'd1) : gain_i_reg;
                a_neg = gain_i_reg[31];
                b_mag = acc_reg[47] ? (~acc_reg + 48'd1) : acc_reg;
                b_neg = acc_reg[47];
            end
            default:
            begin
                a_mag = '0;
            end
        endcase
    end

    // upper half of b first, then shift and add the lower half
    logic [55:0] pp;
    assign pp = a_mag * (cmd.mul_hi ? b_mag[47:24] : b_mag[23:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_hi)
        begin
            prod_reg <= 80'(pp);
            neg_reg  <= a_neg ^ b_neg;
        end
        else if (cmd.mul_lo)
        begin
            prod_reg <= (prod_reg << 24) + 80'(pp);
        end
    end

    // (a*b)>>16, magnitude held to 2^47, sign restored
    logic        mul_ovf;
    logic [47:0] mul_r;
    logic signed [48:0] mul_res;
    assign mul_ovf = (|prod_reg[79:64]) || (prod_reg[63:16] > 48'h8000_0000_0000);
    assign mul_r   = mul_ovf ? 48'h8000_0000_0000 : prod_reg[63:16];
    assign mul_res = neg_reg ? -$signed({1'b0, mul_r}) : $signed({1'b0, mul_r});

    // tentative integral, saturated to 48 bits
    logic signed [49:0] tsum;
    logic signed [47:0] tent_sat;
    assign tsum = {{2{acc_reg[47]}}, acc_reg} + {mul_res[48], mul_res};
    always_comb
    begin
        if (tsum > 50'sd140737488355327)
            tent_sat = 48'sh7FFF_FFFF_FFFF;
        else if (tsum < -50'sd140737488355328)
            tent_sat = 48'sh8000_0000_0000;
        else
            tent_sat = tsum[47:0];
    end

    // ---------------- divider: two restoring steps a cycle
    logic signed [33:0] diff;
    logic [33:0]        diff_mag;
    logic [16:0]        t1, t2;
    logic               ge1, ge2;
    logic [15:0]        r1;
    logic [49:0]        q1;

    assign diff = dom_reg ? (34'(last_sensed_reg) - 34'(sensed_reg))
                          : (34'(err_reg) - 34'(last_err_reg));
    assign diff_mag = diff[33] ? (~diff + 34'd1) : diff;

    assign t1  = {rem_reg, quo_reg[49]};
    assign ge1 = t1 >= {1'b0, dt_reg};
    assign r1  = ge1 ? 16'(t1 - {1'b0, dt_reg}) : t1[15:0];
    assign q1  = {quo_reg[48:0], ge1};
    assign t2  = {r1, q1[49]};
    assign ge2 = t2 >= {1'b0, dt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            quo_reg  <= hist_reg ? {diff_mag, 16'd0} : '0;
            rem_reg  <= '0;
            dneg_reg <= diff[33];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {q1[48:0], ge2};
            rem_reg <= ge2 ? 16'(t2 - {1'b0, dt_reg}) : t2[15:0];
        end
    end

    // quotient saturated to signed 32 bits
    logic signed [31:0] deriv_sat;
    always_comb
    begin
        if (dneg_reg)
            deriv_sat = (quo_reg > 50'h0_8000_0000) ? 32'sh8000_0000
                                                     : (~quo_reg[31:0] + 32'd1);
        else
            deriv_sat = (quo_reg > 50'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_reg[31:0];
    end

    // ---------------- sum, clamp and anti-windup test
    logic signed [50:0] s51;
    logic signed [39:0] raw_sat;
    logic signed [39:0] floor40, ceil40, lo40, drv40;
    logic               held_now;

    assign s51 = {{2{p_reg[48]}}, p_reg}
               + (cmd.sum_id ? ({{2{i_reg[48]}}, i_reg} + {{2{d_reg[48]}}, d_reg}) : 51'sd0);
    always_comb
    begin
        if (s51 > 51'sd549755813887)
            raw_sat = 40'sh7F_FFFF_FFFF;
        else if (s51 < -51'sd549755813888)
            raw_sat = 40'sh80_0000_0000;
        else
            raw_sat = s51[39:0];
    end

    assign floor40 = {{8{floor_reg[31]}}, floor_reg};
    assign ceil40  = {{8{ceil_reg[31]}}, ceil_reg};
    assign lo40    = (raw_reg < floor40) ? floor40 : raw_reg;
    assign drv40   = (lo40 > ceil40) ? ceil40 : lo40;
    assign held_now = ((raw_reg > drv40) && !err_reg[32] && (err_reg != 33'sd0))
                   || ((raw_reg < drv40) && err_reg[32]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            sensed_reg <= sensed;
            dt_reg     <= step_time;
            err_reg    <= 33'(target) - 33'(sensed);
        end
        case (cmd.take)
            pidaw_pkg::TK_P:    p_reg    <= mul_res;
            pidaw_pkg::TK_D:    d_reg    <= mul_res;
            pidaw_pkg::TK_I:    i_reg    <= mul_res;
            pidaw_pkg::TK_TENT: tent_reg <= tent_sat;
            default:            ;
        endcase
        if (cmd.deriv_take)
            deriv_reg <= deriv_sat;
        if (cmd.sum)
            raw_reg <= raw_sat;
        if (cmd.load)
            held_reg <= 1'b0;
        else if (cmd.check)
            held_reg <= held_now;
        if (cmd.finish)
        begin
            drive         <= mode_reg ? 32'sd0 : drv40[31:0];
            raw_sum       <= mode_reg ? 40'sd0 : raw_reg;
            integral_held <= mode_reg ? 1'b0 : held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            last_sensed_reg <= '0;
            last_err_reg    <= '0;
            hist_reg        <= 1'b0;
            last_raw_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (mode_reg)
                begin
                    acc_reg         <= '0;
                    last_sensed_reg <= '0;
                    last_err_reg    <= '0;
                    hist_reg        <= 1'b0;
                    last_raw_reg    <= '0;
                end
                else if (dt_reg == 16'd0)
                begin
                    last_raw_reg <= raw_reg;
                end
                else
                begin
                    if (!held_reg)
                        acc_reg <= tent_reg;
                    last_sensed_reg <= sensed_reg;
                    last_err_reg    <= err_reg;
                    hist_reg        <= 1'b1;
                    last_raw_reg    <= raw_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clr      = mode_reg;
    assign stat.dt_zero  = (dt_reg == 16'd0);
    assign stat.div_last = (cnt_reg == 5'(pidaw_pkg::DIV_STEPS - 1));
    assign stat.held_now = held_now;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

// File: sim/pid_controller_anti_windup_unit_test.sv
// Self-checking testbench for the PID anti-windup unit: directed and random requests against a local predictor.
`timescale 1ns / 1ps
module pid_controller_anti_windup_unit_test;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam longint LIM47 = 64'sd1 <<< 47;
    localparam longint MAX40 = (64'sd1 <<< 39) - 1;
    localparam longint MIN40 = -(64'sd1 <<< 39);
    localparam int SETTLE = 80;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic        mode;
        logic [31:0] target;
        logic [31:0] sensed;
        logic [15:0] step_time;
    } request_t;

    typedef struct {
        logic [31:0] drive;
        logic [39:0] raw_sum;
        logic        held;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = 1'b0;
    logic signed [31:0] target = '0;
    logic signed [31:0] sensed = '0;
    logic [15:0] step_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] drive;
    logic signed [39:0] raw_sum;
    logic integral_held;

    pid_controller_anti_windup_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .target(target), .sensed(sensed), .step_time(step_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .drive(drive), .raw_sum(raw_sum), .integral_held(integral_held)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Predictor copy of registers and state
    longint kp, ki, kd, lo_lim, hi_lim;
    logic   on_meas;
    longint acc, prev_meas, prev_err, prev_raw;
    logic   have_prev;

    request_t pending[$];
    answer_t  awaited[$];
    int       errors = 0;
    bit       calm = 1'b0;
    int       cycles = 0;

    function automatic logic [63:0] absval(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    // (a*b)>>16 toward zero, magnitude capped at 2^47
    function automatic longint qmul(longint a, longint b);
        logic [127:0] pr;
        logic [127:0] r;
        pr = {64'd0, absval(a)} * {64'd0, absval(b)};
        r = pr >> 16;
        if (r > 128'(LIM47))
            r = 128'(LIM47);
        return ((a < 0) != (b < 0)) ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint limit_drive(longint v);
        if (v < lo_lim) v = lo_lim;
        if (v > hi_lim) v = hi_lim;
        return v;
    endfunction

    function automatic void reset_model();
        kp = 65536; ki = 0; kd = 0;
        lo_lim = -64'sd2147483648; hi_lim = 64'sd2147483647;
        on_meas = 1'b0;
        acc = 0; prev_meas = 0; prev_err = 0; prev_raw = 0; have_prev = 1'b0;
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            pidaw_pkg::CFG_GAIN_P:        kp = longint'($signed(val));
            pidaw_pkg::CFG_GAIN_I:        ki = longint'($signed(val));
            pidaw_pkg::CFG_GAIN_D:        kd = longint'($signed(val));
            pidaw_pkg::CFG_DRIVE_FLOOR:   lo_lim = longint'($signed(val));
            pidaw_pkg::CFG_DRIVE_CEILING: hi_lim = longint'($signed(val));
            pidaw_pkg::CFG_DERIV_ON_MEAS: on_meas = val[0];
            default: ;
        endcase
    endfunction

    function automatic answer_t predict_pid(request_t rq);
        answer_t res;
        longint meas, err, p, d, der, diff, inc, tent, raw, drv;
        logic [63:0] q, m, dt;
        logic held;
        meas = longint'($signed(rq.sensed));
        err = longint'($signed(rq.target)) - meas;
        dt = 64'(rq.step_time);
        der = 0;
        held = 1'b0;
        if (rq.mode)
        begin
            acc = 0; prev_meas = 0; prev_err = 0; prev_raw = 0; have_prev = 1'b0;
            res.drive = '0; res.raw_sum = '0; res.held = 1'b0;
            return res;
        end
        p = qmul(kp, err);
        if (dt == 0)
        begin
            raw = clip(p, MIN40, MAX40);
            prev_raw = raw;
            drv = limit_drive(raw);
        end
        else
        begin
            if (have_prev)
            begin
                diff = on_meas ? (prev_meas - meas) : (err - prev_err);
                q = (absval(diff) << 16) / dt;
                if (diff < 0)
                    der = (q > 64'h8000_0000) ? -64'sd2147483648 : -$signed(q);
                else
                    der = (q > 64'h7fff_ffff) ? 64'sd2147483647 : $signed(q);
            end
            d = qmul(kd, der);
            m = (absval(err) * dt) >> 16;
            inc = (err < 0) ? -$signed(m) : $signed(m);
            tent = clip(acc + inc, -LIM47, LIM47 - 1);
            raw = clip(p + qmul(ki, tent) + d, MIN40, MAX40);
            drv = limit_drive(raw);
            // withhold integration when the clamp pushes against the error
            if ((raw > drv && err > 0) || (raw < drv && err < 0))
            begin
                held = 1'b1;
                raw = clip(p + qmul(ki, acc) + d, MIN40, MAX40);
                drv = limit_drive(raw);
            end
            else
                acc = tent;
            prev_meas = meas;
            prev_err = err;
            have_prev = 1'b1;
            prev_raw = raw;
        end
        res.drive = drv[31:0];
        res.raw_sum = raw[39:0];
        res.held = held;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request driver
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                awaited.push_back(predict_pid('{mode, target, sensed, step_time}));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    request_t nx;
                    nx = pending.pop_front();
                    mode <= nx.mode;
                    target <= nx.target;
                    sensed <= nx.sensed;
                    step_time <= nx.step_time;
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    int recv_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("unexpected result drive=%h raw_sum=%h", drive, raw_sum);
                    errors++;
                end
                else
                begin
                    answer_t ex;
                    ex = awaited.pop_front();
                    if (drive !== ex.drive)
                    begin
                        $error("drive: expected %h, got %h", ex.drive, drive);
                        errors++;
                    end
                    if (raw_sum !== ex.raw_sum)
                    begin
                        $error("raw_sum: expected %h, got %h", ex.raw_sum, raw_sum);
                        errors++;
                    end
                    if (integral_held !== ex.held)
                    begin
                        $error("integral_held: expected %b, got %b", ex.held, integral_held);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pid_controller_anti_windup_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        apply_cfg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending.size() > 0 || in_valid || awaited.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                             logic [31:0] lo, logic [31:0] hi, logic dm);
        write_reg(pidaw_pkg::CFG_GAIN_P, p);
        write_reg(pidaw_pkg::CFG_GAIN_I, i);
        write_reg(pidaw_pkg::CFG_GAIN_D, d);
        write_reg(pidaw_pkg::CFG_DRIVE_FLOOR, lo);
        write_reg(pidaw_pkg::CFG_DRIVE_CEILING, hi);
        write_reg(pidaw_pkg::CFG_DERIV_ON_MEAS, {31'd0, dm});
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1, 2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 19))
            0, 1: return 16'd0;
            2: return 16'hffff;
            3: return 16'd1;
            4, 5, 6: return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic queue_req(logic md, logic [31:0] tg, logic [31:0] sn, logic [15:0] st);
        pending.push_back('{md, tg, sn, st});
    endtask

    initial
    begin
        logic [31:0] lo, hi, meas;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: a few plain updates
        queue_req(1'b0, 32'h0001_0000, 32'h0, 16'h1000);
        queue_req(1'b0, 32'h7fff_ffff, 32'h8000_0000, 16'h0);
        queue_req(1'b0, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        drain();

        // Tight clamp with strong integral gain, so windup appears
        write_all(32'h0002_0000, 32'h0001_0000, 32'h0000_4000,
                  32'hfff6_0000, 32'h000a_0000, 1'b0);
        queue_req(1'b1, 32'h0, 32'h0, 16'h0);
        queue_req(1'b0, 32'h0064_0000, 32'h0, 16'h4000);
        queue_req(1'b0, 32'h0064_0000, 32'h0001_0000, 16'h4000);
        queue_req(1'b0, 32'h0000_8000, 32'h0, 16'h0);
        queue_req(1'b0, 32'hff9c_0000, 32'h0, 16'h0001);
        queue_req(1'b0, 32'h7fff_ffff, 32'h8000_0000, 16'h0001);
        queue_req(1'b0, 32'h8000_0000, 32'h7fff_ffff, 16'h0001);
        queue_req(1'b0, 32'h0, 32'h0, 16'hffff);
        queue_req(1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        queue_req(1'b0, 32'h0, 32'h0005_0000, 16'h8000);
        drain();

        // Floor above ceiling, derivative on measurement, extreme gains
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h0010_0000, 32'hfff0_0000, 1'b1);
        write_reg(CFG_UNUSED, 32'hdead_beef);
        queue_req(1'b0, 32'h0001_0000, 32'h0, 16'h0100);
        queue_req(1'b0, 32'h0, 32'h7fff_ffff, 16'h0001);
        queue_req(1'b0, 32'h0, 32'h8000_0000, 16'h0001);
        queue_req(1'b0, 32'h0002_0000, 32'h0003_0000, 16'h0);
        queue_req(1'b0, 32'hffff_0000, 32'h0001_0000, 16'hffff);
        queue_req(1'b1, 32'h0, 32'h0, 16'h0);
        queue_req(1'b0, 32'h8000_0000, 32'h0, 16'h0002);
        drain();

        // Random phases, each ending in a full drain
        for (int ph = 0; ph < 12; ph++)
        begin
            calm = (ph % 4 == 3);
            lo = pick_value();
            hi = pick_value();
            if ($urandom_range(0, 2) == 0)
            begin
                lo = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 21));
                hi = lo + $urandom_range(0, 1 << 21);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                lo = 32'h8000_0000;
                hi = 32'h7fff_ffff;
            end
            write_all(pick_gain(), pick_gain(), pick_gain(), lo, hi, 1'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg(3'($urandom_range(6, 7)), $urandom);
            meas = pick_value();
            for (int k = 0; k < 82; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                    queue_req(1'b1, $urandom, $urandom, 16'($urandom));
                else if ($urandom_range(0, 3) != 0)
                begin
                    // tracking loop: slowly moving measurement around a setpoint
                    meas = meas + 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                    queue_req(1'b0, ($urandom_range(0, 9) == 0) ? pick_value() : meas
                              + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                              meas, pick_step());
                end
                else
                    queue_req(1'b0, pick_value(), pick_value(), pick_step());
            end
            drain();
        end

        if (errors == 0 && awaited.size() == 0)
            $display("pid_controller_anti_windup_unit: match");
        else
            $display("pid_controller_anti_windup_unit: mismatch");
        $finish;
    end
endmodule

// File: files.f
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_ctrl.sv
rtl/core/pidaw_dp.sv
rtl/core/pid_controller_anti_windup_unit.sv
sim/pid_controller_anti_windup_unit_test.sv
